>>> rtl/assert_macros.svh
// Assertion helpers included by yaw_drift_differential_speed.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define YDDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ydds assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define YDDS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ydds assertion failed");

`endif

>>> rtl/ydds_pkg.sv
package ydds_pkg;

  // Default yaw fixed-point format (Q8.8)
  localparam int unsigned YAW_FRAC_BITS = 8;

  // Fixed field widths
  localparam int unsigned YAW_W   = 17;
  localparam int unsigned ERR_W   = YAW_W + 1;
  localparam int unsigned SPEED_W = 9;
  localparam int unsigned PWM_W   = 8;
  localparam int unsigned THR_W   = 12;

  // APB register map
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SIGNED_SPEED    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CORR_ENABLE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW_THRESHOLD   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_CORRECTION = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CORRECTION_STEP = 3'd4;

  // Register reset values
  localparam logic [SPEED_W-1:0] RST_SIGNED_SPEED    = 9'd0;
  localparam logic               RST_CORR_ENABLE     = 1'b1;
  localparam logic [THR_W-1:0]   RST_YAW_THRESHOLD   = 12'd128;
  localparam logic [PWM_W-1:0]   RST_BASE_CORRECTION = 8'd20;
  localparam logic [PWM_W-1:0]   RST_CORRECTION_STEP = 8'd40;

  // Shared multiplier operand widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Reciprocal multiply constants: x/100 exact for x < 25600, x/10 exact for x < 4096
  localparam int unsigned PART_W         = 15;
  localparam logic [12:0] RECIP_100      = 13'd5243;
  localparam int unsigned RECIP_100_SHR  = 19;
  localparam int unsigned SMOOTH_W       = 12;
  localparam logic [12:0] RECIP_10       = 13'd6554;
  localparam int unsigned RECIP_10_SHR   = 16;

  // Square root works on |err| in degrees with 8 extra fraction bits -> root in 1/16
  localparam int unsigned SQRT_PRE_SHIFT = 8;
  // corr * 2 * s / 16 = (corr * s) >> 3
  localparam int unsigned CORR_SHR       = 3;
  localparam int unsigned CORR_W         = 16;

endpackage

>>> rtl/ydds_isqrt.sv
module ydds_isqrt #(
  parameter int unsigned InW = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [InW-1:0]           value_i,
  output logic                     busy_o,
  output logic [(InW+1)/2-1:0]     root_o
);

  localparam int unsigned Iters = (InW + 1) / 2;
  localparam int unsigned NW    = 2 * Iters;
  localparam int unsigned CntW  = $clog2(Iters + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   rem_q, rem_d;
  logic [NW-1:0]   res_q, res_d;
  logic [NW-1:0]   bit_q, bit_d;
  logic [NW:0]     trial;

  // One root bit per cycle: trial subtract of res + bit
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Iters);
      rem_d  = NW'(value_i);
      res_d  = '0;
      bit_d  = {2'b01, {(NW-2){1'b0}}};
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[NW-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = res_q[Iters-1:0];

endmodule

>>> rtl/yaw_drift_differential_speed.sv
// Flow: a start item is taken from idle and gives no result; a tick with correction off
// goes straight to S_FIN; a tick inside the dead band runs S_ERR, S_MAG, S_CMP, then the
// smoothing states S_SML, S_SMR, S_RES; a corrected tick also runs the shared multiplier
// passes and waits in S_WSQ for the bit-serial square root, sized by YawFracBits (Q8.8).
// Throughput: one item at a time; for a tick, in_stall_o is high from acceptance until the result is
// registered. Reset (async, active low) restores register defaults and clears yaw/speeds.
`include "assert_macros.svh"

module yaw_drift_differential_speed #(
  parameter int unsigned YawFracBits = ydds_pkg::YAW_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [ydds_pkg::YAW_W-1:0]    yaw_sample_i,
  // result item channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ydds_pkg::SPEED_W-1:0]  left_speed_o,
  output logic signed [ydds_pkg::SPEED_W-1:0]  right_speed_o,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ydds_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ydds_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ydds_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int unsigned TenW    = YawFracBits + 4;
  localparam logic [TenW-1:0] Ten = TenW'(10) << YawFracBits;
  localparam int unsigned SqInW   = ydds_pkg::YAW_W + ydds_pkg::SQRT_PRE_SHIFT - YawFracBits;
  localparam int unsigned SqRootW = (SqInW + 1) / 2;
  localparam int unsigned SqWideW = ydds_pkg::YAW_W + ydds_pkg::SQRT_PRE_SHIFT;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_MAG  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_M4   = 4'd6;
  localparam logic [3:0] S_WSQ  = 4'd7;
  localparam logic [3:0] S_C    = 4'd8;
  localparam logic [3:0] S_SML  = 4'd9;
  localparam logic [3:0] S_SMR  = 4'd10;
  localparam logic [3:0] S_RES  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // Configuration registers
  logic [ydds_pkg::SPEED_W-1:0] speed_q;
  logic                         corr_en_q;
  logic [ydds_pkg::THR_W-1:0]   thr_q;
  logic [ydds_pkg::PWM_W-1:0]   base_corr_q;
  logic [ydds_pkg::PWM_W-1:0]   step_q;

  // Control and tracked state
  logic [3:0]                   state_q, state_d;
  logic signed [ydds_pkg::YAW_W-1:0] ref_q;
  logic [ydds_pkg::PWM_W-1:0]   prev_l_q, prev_r_q;
  logic                         out_valid_q;

  // Datapath registers
  logic signed [ydds_pkg::YAW_W-1:0] sample_q;
  logic signed [ydds_pkg::ERR_W-1:0] err_q;
  logic [ydds_pkg::YAW_W-1:0]   mag_q;
  logic [ydds_pkg::PWM_W-1:0]   corr_q;
  logic [ydds_pkg::PWM_W-1:0]   tgt_l_q, tgt_r_q;
  logic [ydds_pkg::SPEED_W-1:0] res_l_q, res_r_q;
  logic [ydds_pkg::SPEED_W-1:0] out_l_q, out_r_q;
  logic [ydds_pkg::MUL_P_W-1:0] prod_q;

  // Shared multiplier operands
  logic [ydds_pkg::MUL_A_W-1:0] mul_a;
  logic [ydds_pkg::MUL_B_W-1:0] mul_b;

  logic                         in_acc, cfg_wr, out_free;
  logic [ydds_pkg::REG_IDX_W-1:0] cfg_idx;

  // Speed decode: magnitude saturated to 255, forward when above zero
  logic [ydds_pkg::SPEED_W-1:0] spd_mag;
  logic [ydds_pkg::PWM_W-1:0]   base;
  logic                         forward;
  logic [ydds_pkg::SPEED_W-1:0] dis_val;

  always_comb begin
    spd_mag = speed_q[ydds_pkg::SPEED_W-1] ? (~speed_q + 1'b1) : speed_q;
    base    = spd_mag[ydds_pkg::SPEED_W-1] ? {ydds_pkg::PWM_W{1'b1}}
                                           : spd_mag[ydds_pkg::PWM_W-1:0];
    forward = !speed_q[ydds_pkg::SPEED_W-1] && (speed_q != '0);
    dis_val = forward ? {1'b0, base} : (~{1'b0, base} + 1'b1);
  end

  // Correction terms
  logic                         above;
  logic [TenW-1:0]              ec;
  logic                         step_ge;
  logic [ydds_pkg::PWM_W-1:0]   dm;
  logic [ydds_pkg::MUL_P_W-1:0] prod_shr;
  logic [ydds_pkg::PART_W-1:0]  part_v;
  logic [ydds_pkg::PWM_W-1:0]   part;
  logic [ydds_pkg::PWM_W-1:0]   corr;
  logic [ydds_pkg::CORR_W-1:0]  cval;
  logic [ydds_pkg::YAW_W-1:0]   up_sum;
  logic [ydds_pkg::PWM_W-1:0]   up_t, dn_t;
  logic [SqWideW-1:0]           sq_wide;
  logic [SqInW-1:0]             sq_in;
  logic                         sq_start, sq_busy;
  logic [SqRootW-1:0]           sq_root;

  always_comb begin
    above    = mag_q > ydds_pkg::YAW_W'(thr_q);
    ec       = (mag_q < ydds_pkg::YAW_W'(Ten)) ? mag_q[TenW-1:0] : Ten;
    step_ge  = step_q >= base_corr_q;
    dm       = step_ge ? (step_q - base_corr_q) : (base_corr_q - step_q);
    prod_shr = prod_q >> (2 * YawFracBits);
    part_v   = prod_shr[ydds_pkg::PART_W-1:0];
    part     = prod_q[ydds_pkg::RECIP_100_SHR +: ydds_pkg::PWM_W];
    corr     = step_ge ? (base_corr_q + part) : (base_corr_q - part);
    cval     = prod_q[ydds_pkg::CORR_SHR +: ydds_pkg::CORR_W];
    up_sum   = ydds_pkg::YAW_W'(base) + ydds_pkg::YAW_W'(cval);
    up_t     = (up_sum > ydds_pkg::YAW_W'({ydds_pkg::PWM_W{1'b1}}))
               ? {ydds_pkg::PWM_W{1'b1}} : up_sum[ydds_pkg::PWM_W-1:0];
    dn_t     = (cval >= ydds_pkg::CORR_W'(base)) ? '0 : (base - cval[ydds_pkg::PWM_W-1:0]);
    sq_wide  = {mag_q, {ydds_pkg::SQRT_PRE_SHIFT{1'b0}}} >> YawFracBits;
    sq_in    = sq_wide[SqInW-1:0];
    sq_start = (state_q == S_CMP) && above;
  end

  // Smoothing numerators 7*prev + 3*target
  logic [ydds_pkg::SMOOTH_W-1:0] sum_l, sum_r;
  logic [ydds_pkg::PWM_W-1:0]    new_prev;

  always_comb begin
    sum_l = ({1'b0, prev_l_q, 3'b000} - ydds_pkg::SMOOTH_W'(prev_l_q))
          + ydds_pkg::SMOOTH_W'({tgt_l_q, 1'b0}) + ydds_pkg::SMOOTH_W'(tgt_l_q);
    sum_r = ({1'b0, prev_r_q, 3'b000} - ydds_pkg::SMOOTH_W'(prev_r_q))
          + ydds_pkg::SMOOTH_W'({tgt_r_q, 1'b0}) + ydds_pkg::SMOOTH_W'(tgt_r_q);
    new_prev = prod_q[ydds_pkg::RECIP_10_SHR +: ydds_pkg::PWM_W];
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_CMP: begin
        mul_a = ydds_pkg::MUL_A_W'(ec);
        mul_b = ydds_pkg::MUL_B_W'(ec);
      end
      S_M2: begin
        mul_a = ydds_pkg::MUL_A_W'(prod_q[2*TenW-1:0]);
        mul_b = ydds_pkg::MUL_B_W'(dm);
      end
      S_M3: begin
        mul_a = ydds_pkg::MUL_A_W'(part_v);
        mul_b = ydds_pkg::MUL_B_W'(ydds_pkg::RECIP_100);
      end
      S_WSQ: begin
        mul_a = ydds_pkg::MUL_A_W'(corr_q);
        mul_b = ydds_pkg::MUL_B_W'(sq_root);
      end
      S_SML: begin
        mul_a = ydds_pkg::MUL_A_W'(sum_l);
        mul_b = ydds_pkg::MUL_B_W'(ydds_pkg::RECIP_10);
      end
      S_SMR: begin
        mul_a = ydds_pkg::MUL_A_W'(sum_r);
        mul_b = ydds_pkg::MUL_B_W'(ydds_pkg::RECIP_10);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Bit-serial square root of |err|, root in 1/16 degree
  ydds_isqrt #(
    .InW (SqInW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_in),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  // Handshakes
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[ydds_pkg::APB_ADDR_W-1:2];

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i) begin
          state_d = corr_en_q ? S_ERR : S_FIN;
        end
      end
      S_ERR: state_d = S_MAG;
      S_MAG: state_d = S_CMP;
      S_CMP: state_d = above ? S_M2 : S_SML;
      S_M2:  state_d = S_M3;
      S_M3:  state_d = S_M4;
      S_M4:  state_d = S_WSQ;
      S_WSQ: begin
        if (!sq_busy) begin
          state_d = S_C;
        end
      end
      S_C:   state_d = S_SML;
      S_SML: state_d = S_SMR;
      S_SMR: state_d = S_RES;
      S_RES: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and tracked yaw/speeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      speed_q     <= ydds_pkg::RST_SIGNED_SPEED;
      corr_en_q   <= ydds_pkg::RST_CORR_ENABLE;
      thr_q       <= ydds_pkg::RST_YAW_THRESHOLD;
      base_corr_q <= ydds_pkg::RST_BASE_CORRECTION;
      step_q      <= ydds_pkg::RST_CORRECTION_STEP;
      ref_q       <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      state_q <= state_d;

      // result register
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // register writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          ydds_pkg::REG_SIGNED_SPEED:    speed_q     <= pwdata[ydds_pkg::SPEED_W-1:0];
          ydds_pkg::REG_CORR_ENABLE:     corr_en_q   <= pwdata[0];
          ydds_pkg::REG_YAW_THRESHOLD:   thr_q       <= pwdata[ydds_pkg::THR_W-1:0];
          ydds_pkg::REG_BASE_CORRECTION: base_corr_q <= pwdata[ydds_pkg::PWM_W-1:0];
          ydds_pkg::REG_CORRECTION_STEP: step_q      <= pwdata[ydds_pkg::PWM_W-1:0];
          default: ;
        endcase
      end

      // start item: latch reference, preset smoothed speeds
      if (in_acc && !operation_i) begin
        ref_q    <= yaw_sample_i;
        prev_l_q <= base;
        prev_r_q <= base;
      end

      if (state_q == S_SMR) begin
        prev_l_q <= new_prev;
      end
      if (state_q == S_RES) begin
        prev_r_q <= new_prev;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= yaw_sample_i;
      res_l_q  <= dis_val;
      res_r_q  <= dis_val;
    end
    if (state_q == S_ERR) begin
      err_q <= ydds_pkg::ERR_W'(sample_q) - ydds_pkg::ERR_W'(ref_q);
    end
    if (state_q == S_MAG) begin
      mag_q <= err_q[ydds_pkg::ERR_W-1] ? ydds_pkg::YAW_W'(-err_q)
                                        : err_q[ydds_pkg::YAW_W-1:0];
    end
    // inside the dead band both targets are the base speed
    if (state_q == S_CMP) begin
      tgt_l_q <= base;
      tgt_r_q <= base;
    end
    if (state_q == S_M4) begin
      corr_q <= corr;
    end
    // positive error pushes left up, right down
    if (state_q == S_C) begin
      tgt_l_q <= err_q[ydds_pkg::ERR_W-1] ? dn_t : up_t;
      tgt_r_q <= err_q[ydds_pkg::ERR_W-1] ? up_t : dn_t;
    end
    if (state_q == S_RES) begin
      res_l_q <= forward ? {1'b0, prev_l_q} : (~{1'b0, prev_l_q} + 1'b1);
      res_r_q <= forward ? {1'b0, new_prev} : (~{1'b0, new_prev} + 1'b1);
    end
    if (state_q == S_FIN && out_free) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      ydds_pkg::REG_SIGNED_SPEED:    prdata = ydds_pkg::APB_DATA_W'(speed_q);
      ydds_pkg::REG_CORR_ENABLE:     prdata = ydds_pkg::APB_DATA_W'(corr_en_q);
      ydds_pkg::REG_YAW_THRESHOLD:   prdata = ydds_pkg::APB_DATA_W'(thr_q);
      ydds_pkg::REG_BASE_CORRECTION: prdata = ydds_pkg::APB_DATA_W'(base_corr_q);
      ydds_pkg::REG_CORRECTION_STEP: prdata = ydds_pkg::APB_DATA_W'(step_q);
      default:                       prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = out_l_q;
  assign right_speed_o = out_r_q;

  // Checks
  `YDDS_ASSERT_NXT(a_tick_goes_busy, in_valid_i && !in_stall_o && operation_i, in_stall_o)
  `YDDS_ASSERT_NXT(a_start_no_result,
                   in_valid_i && !in_stall_o && !operation_i && !out_valid_o, !out_valid_o)
  `YDDS_ASSERT_NXT(a_fin_holds, state_q == S_FIN && out_valid_o && out_stall_i, state_q == S_FIN)
  `YDDS_ASSERT_IMP(a_sqrt_inside_item, sq_busy, state_q != S_IDLE)

endmodule
